/* rtl/ptd_pkg.sv */
// ptd_pkg: types and constants shared by the periodic task dispatcher
// holds operation codes, result kinds, sequencer states and memory write controls
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

	// field widths fixed by the item format
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned TIX_W      = 3;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned SLOT_W     = 3;

	// at most this many results per tick are reported
	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// operation carried by an input item
	typedef enum logic [MODE_W-1:0] {
		MODE_TICK   = 2'd0,
		MODE_CREATE = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_FORCE  = 2'd3
	} mode_t;

	// kind of a result item
	typedef enum logic [KIND_W-1:0] {
		KIND_CREATED    = 3'd0,
		KIND_FULL       = 3'd1,
		KIND_DELETED    = 3'd2,
		KIND_DEL_FAIL   = 3'd3,
		KIND_FORCED     = 3'd4,
		KIND_FORCE_FAIL = 3'd5,
		KIND_FIRED      = 3'd6,
		KIND_NONE       = 3'd7
	} kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_READ   = 2'd1,
		ST_CHECK  = 2'd2,
		ST_FINISH = 2'd3
	} state_t;

	// write enables of the slot memory
	typedef struct packed {
		logic period_we;
		logic last_run_we;
	} mem_wr_t;

endpackage : ptd_pkg

`default_nettype wire

/* rtl/ptd_slot_mem.sv */
// ptd_slot_mem: per-slot period and last-run memory, one write and one registered read port
// depends on ptd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptd_slot_mem
	import ptd_pkg::*;
#(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned IDX_W = 3
) (
	input  wire logic                clk,
	input  wire mem_wr_t             wr,
	input  wire logic [IDX_W-1:0]    wr_addr,
	input  wire logic [PERIOD_W-1:0] wr_period,
	input  wire logic [TIME_W-1:0]   wr_last_run,
	input  wire logic [IDX_W-1:0]    rd_addr,
	output logic      [PERIOD_W-1:0] rd_period,
	output logic      [TIME_W-1:0]   rd_last_run
);

	logic [PERIOD_W-1:0] period_mem [DEPTH];
	logic [TIME_W-1:0]   last_run_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.period_we) begin
			period_mem[wr_addr] <= wr_period;
		end
		if (wr.last_run_we) begin
			last_run_mem[wr_addr] <= wr_last_run;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_period   <= period_mem[rd_addr];
		rd_last_run <= last_run_mem[rd_addr];
	end

endmodule : ptd_slot_mem

`default_nettype wire

/* rtl/ptd_due_unit.sv */
// ptd_due_unit: shared elapsed-time subtract and compare against a slot's period
// depends on ptd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptd_due_unit
	import ptd_pkg::*;
(
	input  wire logic [TIME_W-1:0]   now_time,
	input  wire logic [TIME_W-1:0]   last_run,
	input  wire logic [PERIOD_W-1:0] period,
	output logic                     due
);

	logic [TIME_W-1:0] elapsed;

	// modular elapsed time, then compare with the zero-extended period
	always_comb begin
		elapsed = now_time - last_run;
		due     = (elapsed >= {{(TIME_W - PERIOD_W){1'b0}}, period});
	end

endmodule : ptd_due_unit

`default_nettype wire

/* rtl/periodic_task_dispatcher.sv */
// Periodic task dispatcher: task slot table with a walking sequencer. Create, delete and
// force-run items each give a single result, pushed from the finish state.
// A tick item walks the slots from index 0 upward through the one slot memory read port
// and the shared elapsed-time compare unit, with a read state and a check state per slot;
// the check waits while a held result cannot go out. A slot that fires and has a body
// gives one fired result, at most MAX_RESULTS per tick; each result is held until the next
// is known, so the final one carries last. A tick that reports nothing gives one none-fired
// result. No new item is taken until the current one has handed over its last result.
// depends on ptd_pkg, ptd_slot_mem and ptd_due_unit
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatcher
	import ptd_pkg::*;
#(
	parameter int unsigned MAX_TASKS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [TIX_W-1:0]    task_index,
	input  wire logic [PERIOD_W-1:0] period,
	input  wire logic                has_function,
	input  wire logic [TIME_W-1:0]   now_time,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [KIND_W-1:0]   kind,
	output logic      [SLOT_W-1:0]   slot,
	output logic                     last
);

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = IDX_W + 1;

	state_t state_q, state_d;

	logic [MAX_TASKS-1:0] live_q, body_q, force_q;
	logic [CNT_W-1:0]     next_free_q;
	logic [IDX_W-1:0]     idx_q;
	logic [RES_CNT_W-1:0] n_q;
	logic [TIME_W-1:0]    now_q;

	logic                 pend_valid_q;
	kind_t                pend_kind_q;
	logic [SLOT_W-1:0]    pend_slot_q;

	logic                 out_valid_q, out_last_q;
	kind_t                out_kind_q;
	logic [SLOT_W-1:0]    out_slot_q;

	logic                 accept, push_ok, push, push_last;
	kind_t                push_kind;
	logic [SLOT_W-1:0]    push_slot;
	logic [IDX_W-1:0]     tix;
	logic                 in_range, table_full;
	logic                 due, fires, report, room, commit, walk_end;

	mem_wr_t              mem_wr;
	logic [IDX_W-1:0]     mem_wr_addr;
	logic [TIME_W-1:0]    mem_wr_last_run;
	logic [PERIOD_W-1:0]  rd_period;
	logic [TIME_W-1:0]    rd_last_run;

	// slot storage and shared compare unit
	ptd_slot_mem #(
		.DEPTH (MAX_TASKS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk         (clk),
		.wr          (mem_wr),
		.wr_addr     (mem_wr_addr),
		.wr_period   (period),
		.wr_last_run (mem_wr_last_run),
		.rd_addr     (idx_q),
		.rd_period   (rd_period),
		.rd_last_run (rd_last_run)
	);

	ptd_due_unit u_due (
		.now_time (now_q),
		.last_run (rd_last_run),
		.period   (rd_period),
		.due      (due)
	);

	// decode of the addressed slot and the walk step
	always_comb begin
		accept     = in_valid && in_ready;
		push_ok    = !out_valid_q || out_ready;
		tix        = IDX_W'(task_index);
		in_range   = ({{(32 - TIX_W){1'b0}}, task_index} < 32'(MAX_TASKS));
		table_full = (next_free_q >= CNT_W'(MAX_TASKS));
		fires      = live_q[idx_q] && (due || force_q[idx_q]);
		report     = fires && body_q[idx_q];
		room       = (n_q < RES_CNT_W'(MAX_RESULTS));
		walk_end   = (idx_q == IDX_W'(MAX_TASKS - 1));
	end

	// next state, memory writes and output pushes
	always_comb begin
		state_d         = state_q;
		in_ready        = (state_q == ST_IDLE);
		push            = 1'b0;
		push_kind       = pend_kind_q;
		push_slot       = pend_slot_q;
		push_last       = 1'b0;
		commit          = 1'b0;
		mem_wr          = '0;
		mem_wr_addr     = idx_q;
		mem_wr_last_run = now_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_TICK) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_FINISH;
					end
					if (mode == MODE_CREATE && !table_full) begin
						mem_wr.period_we   = 1'b1;
						mem_wr.last_run_we = 1'b1;
						mem_wr_addr        = next_free_q[IDX_W-1:0];
						mem_wr_last_run    = '0;
					end
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// under the result limit, a new report pushes out the held one, which must wait for the output
				if (report && pend_valid_q && room) begin
					commit = push_ok;
					push   = push_ok;
				end else begin
					commit = 1'b1;
				end
				if (commit) begin
					mem_wr.last_run_we = report;
					state_d            = walk_end ? ST_FINISH : ST_READ;
				end
			end
			ST_FINISH: begin
				if (push_ok) begin
					push      = 1'b1;
					push_last = 1'b1;
					if (!pend_valid_q) begin
						push_kind = KIND_NONE;
						push_slot = '0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot flags, free pointer, walk index and held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			body_q       <= '0;
			force_q      <= '0;
			next_free_q  <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_valid_q <= 1'b1;
			unique case (mode_t'(mode))
				MODE_TICK: begin
					idx_q        <= '0;
					n_q          <= '0;
					pend_valid_q <= 1'b0;
				end
				MODE_CREATE: begin
					if (!table_full) begin
						live_q[next_free_q[IDX_W-1:0]]  <= 1'b1;
						body_q[next_free_q[IDX_W-1:0]]  <= has_function;
						force_q[next_free_q[IDX_W-1:0]] <= 1'b0;
						next_free_q                     <= next_free_q + CNT_W'(1);
					end
				end
				MODE_DELETE: begin
					if (in_range && live_q[tix]) begin
						live_q[tix]  <= 1'b0;
						body_q[tix]  <= 1'b0;
						force_q[tix] <= 1'b0;
					end
				end
				MODE_FORCE: begin
					if (in_range && live_q[tix] && body_q[tix]) begin
						force_q[tix] <= 1'b1;
					end
				end
				default: begin
					pend_valid_q <= 1'b1;
				end
			endcase
		end else if (state_q == ST_CHECK && commit) begin
			if (fires) begin
				force_q[idx_q] <= 1'b0;
			end
			if (report && room) begin
				pend_valid_q <= 1'b1;
				n_q          <= n_q + RES_CNT_W'(1);
			end
			if (!walk_end) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// held result payload and tick time
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now_time;
			unique case (mode_t'(mode))
				MODE_CREATE: begin
					pend_kind_q <= table_full ? KIND_FULL : KIND_CREATED;
					pend_slot_q <= table_full ? '0 : SLOT_W'(next_free_q);
				end
				MODE_DELETE: begin
					pend_kind_q <= (in_range && live_q[tix]) ? KIND_DELETED : KIND_DEL_FAIL;
					pend_slot_q <= task_index;
				end
				MODE_FORCE: begin
					pend_kind_q <= (in_range && live_q[tix] && body_q[tix]) ?
						KIND_FORCED : KIND_FORCE_FAIL;
					pend_slot_q <= task_index;
				end
				default: begin
					pend_kind_q <= KIND_NONE;
					pend_slot_q <= '0;
				end
			endcase
		end else if (state_q == ST_CHECK && commit && report && room) begin
			pend_kind_q <= KIND_FIRED;
			pend_slot_q <= SLOT_W'(idx_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q <= push_kind;
			out_slot_q <= push_slot;
			out_last_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign slot      = out_slot_q;
	assign last      = out_last_q;

endmodule : periodic_task_dispatcher

`default_nettype wire

/* test/periodic_task_dispatcher_tb.sv */
// periodic_task_dispatcher_tb: self-checking bench for the periodic task dispatcher
// a directed table, then random ticks, creates, deletes and force runs against a shadow table
// depends on ptd_pkg and periodic_task_dispatcher
`timescale 1ns / 1ps

module periodic_task_dispatcher_tb;
	import ptd_pkg::*;

	localparam int unsigned N_SLOTS     = 8;
	localparam int          HOLD_CYCLES = 400;
	localparam int          STALL_LIMIT = 5000;
	localparam int          PER_PHASE   = 106;

	// one input item plus the typed-in expectation for directed rows
	typedef struct packed {
		mode_t                mode;
		logic [TIX_W-1:0]     tix;
		logic [PERIOD_W-1:0]  per;
		logic                 hf;
		logic [TIME_W-1:0]    now;
		logic                 typed;
		kind_t                xkind;
		logic [SLOT_W-1:0]    xslot;
	} stim_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic                last;
	} report_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [MODE_W-1:0]   mode;
	logic [TIX_W-1:0]    task_index;
	logic [PERIOD_W-1:0] period;
	logic                has_function;
	logic [TIME_W-1:0]   now_time;
	logic                out_valid;
	logic                out_ready;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   slot;
	logic                last;

	// shadow slot table
	logic                shadow_live     [N_SLOTS];
	logic                shadow_body     [N_SLOTS];
	logic [PERIOD_W-1:0] shadow_period   [N_SLOTS];
	logic [TIME_W-1:0]   shadow_last_run [N_SLOTS];
	logic                shadow_force    [N_SLOTS];
	int unsigned         shadow_next_free;

	report_t fresh_reports[$];
	report_t pending_reports[$];
	report_t want;

	int  errors        = 0;
	int  quiet_cycles  = 0;
	int  send_idle_pct = 0;
	int  stall_pct     = 0;
	bit  hold_off_req  = 1'b0;

	// directed rows: mode, index, period, has_function, time, typed, kind, slot
	stim_t directed [25] = '{
		'{MODE_TICK,   3'd0, 16'd0,     1'b0, 32'd0,          1'b1, KIND_NONE,       3'd0},
		'{MODE_DELETE, 3'd7, 16'd0,     1'b0, 32'd0,          1'b1, KIND_DEL_FAIL,   3'd7},
		'{MODE_FORCE,  3'd0, 16'd0,     1'b0, 32'd0,          1'b1, KIND_FORCE_FAIL, 3'd0},
		'{MODE_CREATE, 3'd0, 16'h0000,  1'b1, 32'd0,          1'b1, KIND_CREATED,    3'd0},
		'{MODE_CREATE, 3'd0, 16'hFFFF,  1'b0, 32'd0,          1'b1, KIND_CREATED,    3'd1},
		'{MODE_CREATE, 3'd0, 16'd5,     1'b1, 32'd0,          1'b1, KIND_CREATED,    3'd2},
		'{MODE_CREATE, 3'd0, 16'd20,    1'b1, 32'd0,          1'b1, KIND_CREATED,    3'd3},
		'{MODE_CREATE, 3'd0, 16'd1,     1'b0, 32'd0,          1'b1, KIND_CREATED,    3'd4},
		'{MODE_CREATE, 3'd0, 16'hFFFF,  1'b1, 32'd0,          1'b1, KIND_CREATED,    3'd5},
		'{MODE_CREATE, 3'd0, 16'd10,    1'b1, 32'd0,          1'b1, KIND_CREATED,    3'd6},
		'{MODE_CREATE, 3'd0, 16'd3,     1'b1, 32'd0,          1'b1, KIND_CREATED,    3'd7},
		'{MODE_CREATE, 3'd5, 16'd100,   1'b1, 32'hFFFF_FFFF,  1'b1, KIND_FULL,       3'd0},
		'{MODE_TICK,   3'd0, 16'd0,     1'b0, 32'd0,          1'b0, KIND_NONE,       3'd0},
		'{MODE_FORCE,  3'd1, 16'd0,     1'b0, 32'd0,          1'b1, KIND_FORCE_FAIL, 3'd1},
		'{MODE_FORCE,  3'd5, 16'd0,     1'b0, 32'd0,          1'b1, KIND_FORCED,     3'd5},
		'{MODE_FORCE,  3'd4, 16'd0,     1'b0, 32'd0,          1'b1, KIND_FORCE_FAIL, 3'd4},
		'{MODE_TICK,   3'd0, 16'd0,     1'b0, 32'd2,          1'b0, KIND_NONE,       3'd0},
		'{MODE_TICK,   3'd0, 16'd0,     1'b0, 32'hFFFF_FFFF,  1'b0, KIND_NONE,       3'd0},
		'{MODE_TICK,   3'd0, 16'd0,     1'b0, 32'd4,          1'b0, KIND_NONE,       3'd0},
		'{MODE_DELETE, 3'd2, 16'd0,     1'b0, 32'd0,          1'b1, KIND_DELETED,    3'd2},
		'{MODE_DELETE, 3'd2, 16'd0,     1'b0, 32'd0,          1'b1, KIND_DEL_FAIL,   3'd2},
		'{MODE_FORCE,  3'd2, 16'd0,     1'b0, 32'd0,          1'b1, KIND_FORCE_FAIL, 3'd2},
		'{MODE_FORCE,  3'd7, 16'd0,     1'b0, 32'd0,          1'b1, KIND_FORCED,     3'd7},
		'{MODE_TICK,   3'd0, 16'd0,     1'b0, 32'd4,          1'b0, KIND_NONE,       3'd0},
		'{MODE_TICK,   3'd0, 16'd0,     1'b0, 32'h0001_2000,  1'b0, KIND_NONE,       3'd0}
	};

	periodic_task_dispatcher #(
		.MAX_TASKS(N_SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.task_index  (task_index),
		.period      (period),
		.has_function(has_function),
		.now_time    (now_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.slot        (slot),
		.last        (last)
	);

	always #5 clk = ~clk;

	// works out the reports of one item and moves the shadow table on
	function automatic void predict_dispatch(input stim_t s);
		int                hits;
		logic [TIME_W-1:0] elapsed;
		int unsigned       fs;
		fresh_reports.delete();
		hits = 0;
		case (s.mode)
			MODE_CREATE: begin
				fs = shadow_next_free;
				if (fs >= N_SLOTS) begin
					fresh_reports.push_back('{KIND_FULL, 3'd0, 1'b1});
				end else begin
					shadow_live[fs]     = 1'b1;
					shadow_body[fs]     = s.hf;
					shadow_period[fs]   = s.per;
					shadow_last_run[fs] = '0;
					shadow_force[fs]    = 1'b0;
					shadow_next_free    = fs + 1;
					fresh_reports.push_back('{KIND_CREATED, SLOT_W'(fs), 1'b1});
				end
			end
			MODE_DELETE: begin
				if (!shadow_live[s.tix]) begin
					fresh_reports.push_back('{KIND_DEL_FAIL, s.tix, 1'b1});
				end else begin
					shadow_live[s.tix]  = 1'b0;
					shadow_body[s.tix]  = 1'b0;
					shadow_force[s.tix] = 1'b0;
					fresh_reports.push_back('{KIND_DELETED, s.tix, 1'b1});
				end
			end
			MODE_FORCE: begin
				if (!shadow_live[s.tix] || !shadow_body[s.tix]) begin
					fresh_reports.push_back('{KIND_FORCE_FAIL, s.tix, 1'b1});
				end else begin
					shadow_force[s.tix] = 1'b1;
					fresh_reports.push_back('{KIND_FORCED, s.tix, 1'b1});
				end
			end
			default: begin
				// tick: walk the slots upward, elapsed time wraps modulo 2^32
				for (int i = 0; i < N_SLOTS; i++) begin
					if (shadow_live[i]) begin
						elapsed = s.now - shadow_last_run[i];
						if (elapsed >= {16'd0, shadow_period[i]} || shadow_force[i]) begin
							shadow_force[i] = 1'b0;
							if (shadow_body[i]) begin
								shadow_last_run[i] = s.now;
								if (hits < MAX_RESULTS) begin
									fresh_reports.push_back('{KIND_FIRED, SLOT_W'(i), 1'b0});
									hits++;
								end
							end
						end
					end
				end
				if (hits == 0)
					fresh_reports.push_back('{KIND_NONE, 3'd0, 1'b1});
				else
					fresh_reports[fresh_reports.size()-1].last = 1'b1;
			end
		endcase
	endfunction

	// offers one item from a falling edge, waits for acceptance, records what it should give
	task automatic offer_item(input stim_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= s.mode;
		task_index   <= s.tix;
		period       <= s.per;
		has_function <= s.hf;
		now_time     <= s.now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_dispatch(s);
		if (s.typed)
			pending_reports.push_back('{s.xkind, s.xslot, 1'b1});
		else
			foreach (fresh_reports[k])
				pending_reports.push_back(fresh_reports[k]);
		@(negedge clk);
	endtask

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d last %0d", kind, slot, last);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					errors++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		stim_t             s;
		int                r;
		logic [TIME_W-1:0] cur_time;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = '0;
		task_index   = '0;
		period       = '0;
		has_function = 1'b0;
		now_time     = '0;
		cur_time     = 32'h0001_2000;
		for (int i = 0; i < N_SLOTS; i++) begin
			shadow_live[i]     = 1'b0;
			shadow_body[i]     = 1'b0;
			shadow_period[i]   = '0;
			shadow_last_run[i] = '0;
			shadow_force[i]    = 1'b0;
		end
		shadow_next_free = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed[d])
			offer_item(directed[d]);

		// random part in four idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  hold_off_req = 1'b1; end
				1: begin send_idle_pct = 88; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 88; end
				default: begin send_idle_pct = 8; stall_pct = 8; end
			endcase
			repeat (PER_PHASE) begin
				r       = $urandom_range(0, 99);
				s.tix   = TIX_W'($urandom_range(0, 7));
				s.per   = PERIOD_W'($urandom_range(0, 65535));
				s.hf    = 1'($urandom_range(0, 1));
				s.now   = $urandom;
				s.typed = 1'b0;
				s.xkind = KIND_NONE;
				s.xslot = '0;
				if (r < 72) begin
					// mostly a steady clock, sometimes long leaps or a jump anywhere
					s.mode = MODE_TICK;
					r = $urandom_range(0, 99);
					if (r < 80)
						cur_time += $urandom_range(0, 12);
					else if (r < 95)
						cur_time += $urandom_range(1000, 70000);
					else
						cur_time = $urandom;
					s.now = cur_time;
				end else if (r < 90) begin
					s.mode = MODE_FORCE;
				end else if (r < 98) begin
					s.mode = MODE_CREATE;
				end else begin
					s.mode = MODE_DELETE;
				end
				offer_item(s);
			end
		end
		in_valid <= 1'b0;

		// drain, then let the pipeline settle
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
